### sv/sorted_ready_queue_assert.svh
// assertion macros for the sorted ready queue checks
`ifndef SORTED_READY_QUEUE_ASSERT_SVH
`define SORTED_READY_QUEUE_ASSERT_SVH

// same-cycle implication under reset
`define SRQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted ready queue check failed");

// next-cycle implication under reset
`define SRQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted ready queue check failed");

`endif

### sv/srq_pkg.sv
// types, codes and ordering function shared by the sorted ready queue files
package srq_pkg;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } entry_t;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] MODE_UNSORTED = 2'd0;
    localparam logic [1:0] MODE_ARRIVAL  = 2'd1;
    localparam logic [1:0] MODE_BURST    = 2'd2;
    localparam logic [1:0] MODE_PRIORITY = 2'd3;

    // stored entry orders strictly ahead of the new one
    function automatic logic stored_before(input entry_t stored, input entry_t fresh,
                                           input logic [1:0] mode);
        logic res;
        unique case (mode)
            MODE_ARRIVAL: begin
                res = (stored.arrival < fresh.arrival) ||
                      ((stored.arrival == fresh.arrival) && (stored.burst < fresh.burst));
            end
            MODE_BURST: begin
                res = (stored.burst < fresh.burst) ||
                      ((stored.burst == fresh.burst) && (stored.arrival < fresh.arrival));
            end
            MODE_PRIORITY: begin
                res = stored.prio < fresh.prio;
            end
            default: begin
                res = 1'b0;
            end
        endcase
        return res;
    endfunction

endpackage

### sv/sorted_ready_queue.sv
// Ordered task queue held in one single-port-read memory of DEPTH entries and walked by a
// small sequencer, one entry per clock, with one shared key comparator. An add in a sorted
// mode scans the stored entries for its place, then moves the entries from there down by
// one; an add in unsorted mode or into an empty queue skips the scan and goes in at the
// head. A pop or a remove walks all held entries, and a dropped add, an empty pop or any
// other request goes straight to the result. The memory read port and the single
// comparator set how long each request takes. One request is worked on at a time; s_ready
// is high only while the sequencer is idle, and a finished result waits in the output
// register while the next request is taken in; that request then holds in its last step
// until the waiting result is taken.
// sort_mode changes only the placement of later adds; stored entries keep their order.
module sorted_ready_queue
    import srq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_task_id,
    input  logic [15:0] s_arrival_time,
    input  logic [15:0] s_burst_time,
    input  logic [7:0]  s_task_priority,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_valid,
    output logic [7:0]  m_out_id,
    output logic [15:0] m_out_arrival,
    output logic [15:0] m_out_burst,
    output logic [7:0]  m_out_priority,
    output logic [1:0]  m_status,
    output logic [4:0]  m_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_POP,
        S_REMOVE,
        S_FINISH
    } state_t;

    state_t          state_reg;
    logic [1:0]      sort_mode_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   rp_reg;
    logic [CW-1:0]   pos_reg;
    logic [CW-1:0]   kept_reg;
    logic            pipe_reg;
    entry_t          req_reg;
    entry_t          rdata_reg;
    logic            res_valid_reg;
    entry_t          res_entry_reg;
    logic [1:0]      res_status_reg;
    logic            m_valid_reg;
    logic            m_out_valid_reg;
    entry_t          m_entry_reg;
    logic [1:0]      m_status_reg;
    logic [4:0]      m_occupancy_reg;

    entry_t          entry_mem [DEPTH];

    logic [CW-1:0]   rp_inc;
    logic [CW-1:0]   rp_dec;
    logic [CW-1:0]   rp_dec2;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    entry_t          mem_wdata;
    logic            id_match;
    logic            ahead;
    entry_t          s_entry;

    assign rp_inc   = rp_reg + 1'b1;
    assign rp_dec   = rp_reg - 1'b1;
    assign rp_dec2  = rp_reg - 2'd2;
    assign id_match = rdata_reg.id == req_reg.id;
    assign ahead    = stored_before(rdata_reg, req_reg, sort_mode_reg);
    assign s_entry  = '{id: s_task_id, arrival: s_arrival_time, burst: s_burst_time,
                        prio: s_task_priority};

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rdata_reg;
        mem_raddr = rp_reg[AW-1:0];
        unique case (state_reg)
            S_SHIFT: begin
                mem_raddr = rp_dec[AW-1:0];
                if (pipe_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = rp_inc[AW-1:0];
                end else if (rp_reg == pos_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg[AW-1:0];
                    mem_wdata = req_reg;
                end
            end
            S_POP: begin
                if (pipe_reg && (rp_dec != '0)) begin
                    mem_we    = 1'b1;
                    mem_waddr = rp_dec2[AW-1:0];
                end
            end
            S_REMOVE: begin
                if (pipe_reg && !id_match) begin
                    mem_we    = 1'b1;
                    mem_waddr = kept_reg[AW-1:0];
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= entry_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            sort_mode_reg <= MODE_UNSORTED;
            count_reg     <= '0;
            pipe_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                sort_mode_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg        <= s_entry;
                        kept_reg       <= '0;
                        pipe_reg       <= 1'b0;
                        res_valid_reg  <= 1'b0;
                        res_entry_reg  <= '0;
                        unique case (s_cmd)
                            CMD_ADD: begin
                                if (count_reg >= DEPTH_C) begin
                                    rp_reg         <= '0;
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_FINISH;
                                end else if ((sort_mode_reg == MODE_UNSORTED) ||
                                             (count_reg == '0)) begin
                                    pos_reg        <= '0;
                                    rp_reg         <= count_reg;
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_SHIFT;
                                end else begin
                                    rp_reg         <= '0;
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_SCAN;
                                end
                            end
                            CMD_POP: begin
                                rp_reg <= '0;
                                if (count_reg == '0) begin
                                    res_status_reg <= ST_EMPTY;
                                    state_reg      <= S_FINISH;
                                end else begin
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_POP;
                                end
                            end
                            CMD_REMOVE: begin
                                rp_reg         <= '0;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_REMOVE;
                            end
                            default: begin
                                rp_reg         <= '0;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (pipe_reg && (!ahead || (rp_reg == count_reg))) begin
                        pos_reg   <= ahead ? count_reg : rp_dec;
                        rp_reg    <= count_reg;
                        pipe_reg  <= 1'b0;
                        state_reg <= S_SHIFT;
                    end else if (rp_reg < count_reg) begin
                        rp_reg   <= rp_inc;
                        pipe_reg <= 1'b1;
                    end else begin
                        pipe_reg <= 1'b0;
                    end
                end
                S_SHIFT: begin
                    if (rp_reg > pos_reg) begin
                        rp_reg   <= rp_dec;
                        pipe_reg <= 1'b1;
                    end else begin
                        pipe_reg <= 1'b0;
                    end
                    if (!pipe_reg && (rp_reg == pos_reg)) begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_FINISH;
                    end
                end
                S_POP: begin
                    if (rp_reg < count_reg) begin
                        rp_reg   <= rp_inc;
                        pipe_reg <= 1'b1;
                    end else begin
                        pipe_reg <= 1'b0;
                    end
                    if (pipe_reg && (rp_dec == '0)) begin
                        res_valid_reg <= 1'b1;
                        res_entry_reg <= rdata_reg;
                    end
                    if (!pipe_reg && (rp_reg == count_reg)) begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_FINISH;
                    end
                end
                S_REMOVE: begin
                    if (rp_reg < count_reg) begin
                        rp_reg   <= rp_inc;
                        pipe_reg <= 1'b1;
                    end else begin
                        pipe_reg <= 1'b0;
                    end
                    if (pipe_reg && !id_match) begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                    if (!pipe_reg && (rp_reg == count_reg)) begin
                        if (kept_reg == count_reg) begin
                            res_status_reg <= ST_NOTFOUND;
                        end
                        count_reg <= kept_reg;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_out_valid_reg <= res_valid_reg;
                        m_entry_reg     <= res_entry_reg;
                        m_status_reg    <= res_status_reg;
                        m_occupancy_reg <= 5'(count_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = state_reg == S_IDLE;
    assign m_valid        = m_valid_reg;
    assign m_out_valid    = m_out_valid_reg;
    assign m_out_id       = m_entry_reg.id;
    assign m_out_arrival  = m_entry_reg.arrival;
    assign m_out_burst    = m_entry_reg.burst;
    assign m_out_priority = m_entry_reg.prio;
    assign m_status       = m_status_reg;
    assign m_occupancy    = m_occupancy_reg;

endmodule

### sv/srq_checker.sv
// port-level checks for the sorted ready queue and their bind
`include "sorted_ready_queue_assert.svh"

module srq_checker
    import srq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_out_valid,
    input logic [7:0]  m_out_id,
    input logic [15:0] m_out_arrival,
    input logic [15:0] m_out_burst,
    input logic [7:0]  m_out_priority,
    input logic [1:0]  m_status,
    input logic [4:0]  m_occupancy
);

    localparam logic [4:0] FULL_OCC = 5'(DEPTH);

    // a returned entry only comes with ok status
    `SRQ_ASSERT_NOW(a_pop_ok, aclk, aresetn, m_valid && m_out_valid, m_status == ST_OK)

    // no returned entry means zero payload
    `SRQ_ASSERT_NOW(a_empty_payload, aclk, aresetn, m_valid && !m_out_valid,
        (m_out_id == 8'd0) && (m_out_arrival == 16'd0) && (m_out_burst == 16'd0) &&
        (m_out_priority == 8'd0))

    // empty pop reports zero entries
    `SRQ_ASSERT_NOW(a_empty_occ, aclk, aresetn, m_valid && (m_status == ST_EMPTY),
        m_occupancy == 5'd0)

    // dropped add reports a full queue
    `SRQ_ASSERT_NOW(a_full_occ, aclk, aresetn, m_valid && (m_status == ST_FULL),
        m_occupancy == FULL_OCC)

    // stalled result holds
    `SRQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_occupancy) && $stable(m_out_id))

endmodule

bind sorted_ready_queue srq_checker #(.DEPTH(DEPTH)) u_srq_checker (.*);

### sim/sorted_ready_queue_test.sv
// self-checking bench for the sorted ready queue: directed corner requests, then random phases
module sorted_ready_queue_test
    import srq_pkg::*;
();

    localparam int QDEPTH = 16;
    localparam int PHASES = 8;
    localparam int PER_PHASE = 53;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } flow_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } reply_t;

    class ready_queue_scoreboard;
        entry_t     slot [QDEPTH];
        int         held;
        logic [1:0] mode;
        reply_t     pending_replies [$];
        int         mismatches;
        int         checked;
        int         full_drops;
        int         empty_pops;
        int         missing_ids;
        int         pops_served;

        function new();
            held = 0;
            mode = MODE_UNSORTED;
            mismatches = 0;
            checked = 0;
            full_drops = 0;
            empty_pops = 0;
            missing_ids = 0;
            pops_served = 0;
        endfunction

        function void set_mode(logic [1:0] m);
            mode = m;
        endfunction

        function int count();
            return held;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function logic [7:0] pick_stored_id();
            return slot[$urandom_range(0, held - 1)].id;
        endfunction

        // true when the stored entry keeps its place ahead of the new one
        function bit ahead_of(entry_t old_e, entry_t new_e);
            case (mode)
                MODE_ARRIVAL:  return {old_e.arrival, old_e.burst} < {new_e.arrival, new_e.burst};
                MODE_BURST:    return {old_e.burst, old_e.arrival} < {new_e.burst, new_e.arrival};
                MODE_PRIORITY: return old_e.prio < new_e.prio;
                default:       return 1'b0;
            endcase
        endfunction

        function void note_request(logic [1:0] cmd, entry_t req);
            reply_t r;
            int     pos;
            int     kept;
            int     i;
            r = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_ADD: begin
                    if (held >= QDEPTH) begin
                        r.status = ST_FULL;
                        full_drops++;
                    end else begin
                        pos = 0;
                        while (pos < held && ahead_of(slot[pos], req)) pos++;
                        for (i = held; i > pos; i--) slot[i] = slot[i - 1];
                        slot[pos] = req;
                        held++;
                    end
                end
                CMD_POP: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                        empty_pops++;
                    end else begin
                        r.out_valid = 1'b1;
                        r.id = slot[0].id;
                        r.arrival = slot[0].arrival;
                        r.burst = slot[0].burst;
                        r.prio = slot[0].prio;
                        for (i = 1; i < held; i++) slot[i - 1] = slot[i];
                        held--;
                        pops_served++;
                    end
                end
                CMD_REMOVE: begin
                    kept = 0;
                    for (i = 0; i < held; i++) begin
                        if (slot[i].id != req.id) begin
                            slot[kept] = slot[i];
                            kept++;
                        end
                    end
                    if (kept == held) begin
                        r.status = ST_NOTFOUND;
                        missing_ids++;
                    end
                    held = kept;
                end
                default: begin
                end
            endcase
            r.occupancy = held[4:0];
            pending_replies.push_back(r);
        endfunction

        function void check_result(reply_t got);
            reply_t want;
            checked++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply %0d arrived with nothing outstanding", checked);
                return;
            end
            want = pending_replies[0];
            pending_replies.delete(0);
            if (got.out_valid !== want.out_valid || got.id !== want.id ||
                got.arrival !== want.arrival || got.burst !== want.burst ||
                got.prio !== want.prio || got.status !== want.status ||
                got.occupancy !== want.occupancy) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("reply %0d mismatch, expected valid=%0d id=%0d arr=%0d burst=%0d",
                             checked, want.out_valid, want.id, want.arrival, want.burst);
                    $display("    prio=%0d status=%0d occ=%0d", want.prio, want.status,
                             want.occupancy);
                    $display("  actual valid=%0d id=%0d arr=%0d burst=%0d prio=%0d",
                             got.out_valid, got.id, got.arrival, got.burst, got.prio);
                    $display("    status=%0d occ=%0d", got.status, got.occupancy);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = '0;
    logic [7:0]  s_task_id = '0;
    logic [15:0] s_arrival_time = '0;
    logic [15:0] s_burst_time = '0;
    logic [7:0]  s_task_priority = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_out_valid;
    logic [7:0]  m_out_id;
    logic [15:0] m_out_arrival;
    logic [15:0] m_out_burst;
    logic [7:0]  m_out_priority;
    logic [1:0]  m_status;
    logic [4:0]  m_occupancy;

    flow_t                 flow = FLOW_FREE;
    bit                    quiet = 1'b0;
    ready_queue_scoreboard board;
    reply_t                seen;

    sorted_ready_queue #(
        .DEPTH(QDEPTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_task_id(s_task_id),
        .s_arrival_time(s_arrival_time),
        .s_burst_time(s_burst_time),
        .s_task_priority(s_task_priority),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_valid(m_out_valid),
        .m_out_id(m_out_id),
        .m_out_arrival(m_out_arrival),
        .m_out_burst(m_out_burst),
        .m_out_priority(m_out_priority),
        .m_status(m_status),
        .m_occupancy(m_occupancy)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // result side back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            if (!aresetn)
                m_ready = 1'b0;
            else if (!quiet &&
                     ((flow == FLOW_SINK_STALLS && $urandom_range(0, 99) < 52) ||
                      (flow == FLOW_BOTH && $urandom_range(0, 99) < 33)))
                m_ready = 1'b0;
            else
                m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.out_valid = m_out_valid;
            seen.id = m_out_id;
            seen.arrival = m_out_arrival;
            seen.burst = m_out_burst;
            seen.prio = m_out_priority;
            seen.status = m_status;
            seen.occupancy = m_occupancy;
            board.check_result(seen);
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] t_id,
                                input logic [15:0] t_arr, input logic [15:0] t_bur,
                                input logic [7:0] t_pri);
        entry_t req;
        req.id = t_id;
        req.arrival = t_arr;
        req.burst = t_bur;
        req.prio = t_pri;
        @(negedge aclk);
        while (!quiet &&
               ((flow == FLOW_SRC_GAPS && $urandom_range(0, 99) < 52) ||
                (flow == FLOW_BOTH && $urandom_range(0, 99) < 33))) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_cmd = cmd;
        s_task_id = t_id;
        s_arrival_time = t_arr;
        s_burst_time = t_bur;
        s_task_priority = t_pri;
        do @(posedge aclk); while (!s_ready);
        board.note_request(cmd, req);
    endtask

    // hold off new requests until every reply is back
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = m;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.set_mode(m);
    endtask

    initial begin
        #4_000_000;
        $display("timeout with %0d replies outstanding", board.pending());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [1:0]  phase_mode [PHASES];
        flow_t       phase_flow [PHASES];
        logic [1:0]  cmd;
        logic [7:0]  t_id;
        logic [15:0] t_arr;
        logic [15:0] t_bur;
        logic [7:0]  t_pri;
        int          sent;
        int          total;
        int          roll;
        bit          filling;

        phase_mode = '{MODE_UNSORTED, MODE_ARRIVAL, MODE_BURST, MODE_PRIORITY,
                       MODE_PRIORITY, MODE_BURST, MODE_ARRIVAL, MODE_UNSORTED};
        phase_flow = '{FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH,
                       FLOW_FREE, FLOW_BOTH, FLOW_SINK_STALLS, FLOW_SRC_GAPS};
        board = new();
        total = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty queue corners, unused command, duplicate ids, head insert
        send_request(CMD_POP, 8'h00, 16'h0000, 16'h0000, 8'h00);
        send_request(CMD_REMOVE, 8'h5a, 16'h0000, 16'h0000, 8'h00);
        send_request(CMD_UNUSED, 8'hff, 16'hffff, 16'hffff, 8'hff);
        send_request(CMD_ADD, 8'h00, 16'h0000, 16'h0000, 8'h00);
        send_request(CMD_ADD, 8'hff, 16'hffff, 16'hffff, 8'hff);
        send_request(CMD_ADD, 8'hff, 16'h1234, 16'h4321, 8'h80);
        send_request(CMD_REMOVE, 8'hff, 16'hffff, 16'hffff, 8'hff);
        send_request(CMD_POP, 8'h00, 16'h0000, 16'h0000, 8'h00);
        total += 7;

        // fill by priority with ties, then overflow
        settle();
        write_mode(MODE_PRIORITY);
        for (int k = 0; k < QDEPTH; k++) begin
            send_request(CMD_ADD, 8'(k), 16'(k * 4099), 16'(16'hffff - k),
                         (k % 3 == 0) ? 8'hff : ((k % 3 == 1) ? 8'h00 : 8'h7f));
        end
        send_request(CMD_ADD, 8'hee, 16'h0000, 16'h0000, 8'h00);
        send_request(CMD_POP, 8'h00, 16'h0000, 16'h0000, 8'h00);
        total += QDEPTH + 2;

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_mode(phase_mode[p]);
            flow = phase_flow[p];
            sent = 0;
            while (sent < PER_PHASE) begin
                quiet = (sent % 40) < 6;
                filling = ((sent / 30) % 2) == 0;
                roll = $urandom_range(0, 99);
                if (filling)
                    cmd = (roll < 80) ? CMD_ADD : (roll < 90) ? CMD_POP :
                          (roll < 98) ? CMD_REMOVE : CMD_UNUSED;
                else
                    cmd = (roll < 20) ? CMD_ADD : (roll < 70) ? CMD_POP :
                          (roll < 98) ? CMD_REMOVE : CMD_UNUSED;
                t_id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                   : 8'($urandom_range(0, 255));
                if (cmd == CMD_REMOVE && board.count() > 0 && $urandom_range(0, 9) < 7)
                    t_id = board.pick_stored_id();
                // narrow keys force ties, wide keys exercise every bit
                t_arr = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                                                    : 16'($urandom);
                t_bur = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                                                    : 16'($urandom);
                t_pri = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                    : 8'($urandom_range(0, 255));
                send_request(cmd, t_id, t_arr, t_bur, t_pri);
                if (cmd != CMD_UNUSED)
                    sent++;
            end
            total += sent;
            quiet = 1'b0;
        end

        settle();
        flow = FLOW_FREE;
        repeat (40) @(posedge aclk);

        $display("%0d requests over all four sort orders and idle patterns, %0d replies checked",
                 total, board.checked);
        $display("%0d pops served, %0d full drops, %0d empty pops, %0d missing ids, %0d bad",
                 board.pops_served, board.full_drops, board.empty_pops, board.missing_ids,
                 board.mismatches + board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
